// File: sv/stpf_pkg.sv
package stpf_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;
   localparam int IDLE_W = 11;
   localparam int TMO_W  = 8;

   // defaults and internal queue depths
   localparam int FRAME_DEPTH_DEF = 32;
   localparam int CMD_DEPTH       = 2;
   localparam int OUT_DEPTH       = 4;

   // register reset values
   localparam logic [LEN_W-1:0]  MAX_LEN_RST = LEN_W'(32);
   localparam logic [BYTE_W-1:0] TERM_RST    = BYTE_W'(13);
   localparam logic [TMO_W-1:0]  TMO_RST     = TMO_W'(4);

   // register indexes
   localparam logic [1:0] REG_MAX_LEN = 2'd0;
   localparam logic [1:0] REG_TERM    = 2'd1;
   localparam logic [1:0] REG_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      MODE_BYTE       = 2'd0,
      MODE_TICK       = 2'd1,
      MODE_CONNECT    = 2'd2,
      MODE_DISCONNECT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CAUSE_TERM = 2'd0,
      CAUSE_LEN  = 2'd1,
      CAUSE_IDLE = 2'd2
   } cause_type;

   // work for the back end: flush, store, flush, each part optional
   typedef struct packed {
      logic [LEN_W-1:0]  pre_len;
      logic              wr_en;
      logic [LEN_W-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic [LEN_W-1:0]  post_len;
      cause_type         post_cause;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              frame_last;
      cause_type         flush_cause;
   } out_type;

endpackage

// File: sv/serial_to_packet_framer_top.sv
// serial to packet framer
// req channel: push/full queue; each word is a mode (byte, tick, connect,
// disconnect) and a received byte. A word is taken when push is high and
// full is low; it is classified combinationally and, if it stores a byte or
// flushes a frame, queued as work for the back end (two-entry work queue).
// rsp channel: empty/pop queue of frame bytes with last marker and flush
// cause; a four-entry result queue sits in front of the ports.
// csr port: csr_we writes csr_index (0 max length, 1 terminator, 2 idle
// timeout) with csr_wdata in the same cycle.
// throughput: the front takes one word per cycle while the work queue has
// room. The back end steps each work entry through pre-flush, write and
// post-flush states, reading flushed frame bytes from the single-port frame
// store, and takes no new work entry until it is back in idle.
// reset: registers return to 32 / 13 / 4, not connected, queues empty;
// the frame store is not cleared. When the receiver stops popping, the
// result queue fills, the back end holds, the work queue fills and full
// rises; nothing is dropped.
module serial_to_packet_framer_top import stpf_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_mode,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [BYTE_W-1:0] rsp_frame_byte,
   output logic              rsp_frame_last,
   output logic [1:0]        rsp_flush_cause,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [BYTE_W-1:0] csr_wdata
);

   localparam int CMD_W  = $bits(cmd_type);
   localparam int OUT_W  = $bits(out_type);
   localparam int CCNT_W = $clog2(CMD_DEPTH+1);

   logic                           accept;
   logic                           cmd_push;
   cmd_type                        cmd_wdata;
   logic [CMD_W-1:0]               cmd_rbits;
   logic                           cmd_pop;
   logic                           cmd_empty;
   logic                           cmd_full;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
   logic                           out_push;
   out_type                        out_wdata;
   logic [OUT_W-1:0]               out_rbits;
   out_type                        out_head;
   logic                           out_full;
   logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   // front: registers, connection state, classification
   stpf_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_mode    (req_mode),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_wdata)
   );

   // work queue between front and back
   stpf_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .pop   (cmd_pop),
      .rdata (cmd_rbits),
      .empty (cmd_empty),
      .full  (cmd_full),
      .count (cmd_count)
   );

   // back: frame store and readout
   stpf_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_rdata (cmd_type'(cmd_rbits)),
      .cmd_pop   (cmd_pop),
      .out_count (out_count),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wdata)
   );

   // result queue
   stpf_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .pop   (rsp_pop),
      .rdata (out_rbits),
      .empty (rsp_empty),
      .full  (out_full),
      .count (out_count)
   );

   assign out_head        = out_type'(out_rbits);
   assign rsp_frame_byte  = out_head.frame_byte;
   assign rsp_frame_last  = out_head.frame_last;
   assign rsp_flush_cause = out_head.flush_cause;

   // work queue never overruns: full holds off new words
   a_cmd_bound: assert property (@(posedge clock) disable iff (reset)
      !(cmd_push && cmd_full) && (cmd_count <= CCNT_W'(CMD_DEPTH)))
      else $error("work queue overrun");

endmodule

// File: sv/stpf_fifo.sv
module stpf_fifo import stpf_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: sv/stpf_front.sv
module stpf_front import stpf_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        req_mode,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [BYTE_W-1:0] csr_wdata,
   output logic              cmd_push,
   output cmd_type           cmd_data
);

   logic [LEN_W-1:0]  max_len_ff, max_len_in;
   logic [BYTE_W-1:0] term_ff, term_in;
   logic [TMO_W-1:0]  tmo_ff, tmo_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;
   logic              conn_ff, conn_in;
   logic [LEN_W-1:0]  limit;
   logic [LEN_W-1:0]  fill_base;
   logic              len_hit;
   logic              term_hit;
   logic              fire;
   mode_type          mode;

   assign mode = mode_type'(req_mode);

   // effective length limit, clamped to 1..depth
   always_comb begin
      priority if (max_len_ff == '0) begin
         limit = LEN_W'(1);
      end else if (max_len_ff > LEN_W'(FRAME_DEPTH)) begin
         limit = LEN_W'(FRAME_DEPTH);
      end else begin
         limit = max_len_ff;
      end
   end

   assign len_hit   = (fill_ff >= limit);
   assign fill_base = len_hit ? '0 : fill_ff;
   assign term_hit  = (req_rx_byte == term_ff);
   assign fire      = (idle_ff[IDLE_W-1:2] >= {1'b0, tmo_ff});

   // register writes
   always_comb begin
      max_len_in = max_len_ff;
      term_in    = term_ff;
      tmo_in     = tmo_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MAX_LEN: max_len_in = csr_wdata[LEN_W-1:0];
            REG_TERM:    term_in    = csr_wdata;
            REG_TIMEOUT: tmo_in     = csr_wdata[TMO_W-1:0];
            default:     ;
         endcase
      end
   end

   // classify the word and build back-end work
   always_comb begin
      fill_in  = fill_ff;
      idle_in  = idle_ff;
      conn_in  = conn_ff;
      cmd_push = 1'b0;
      cmd_data = '{pre_len: '0, wr_en: 1'b0, wr_addr: '0, wr_data: req_rx_byte,
                   post_len: '0, post_cause: CAUSE_TERM};
      if (accept) begin
         unique case (mode)
            MODE_BYTE: begin
               if (conn_ff) begin
                  idle_in          = '0;
                  cmd_push         = 1'b1;
                  cmd_data.pre_len = len_hit ? fill_ff : '0;
                  cmd_data.wr_en   = 1'b1;
                  cmd_data.wr_addr = fill_base;
                  if (term_hit) begin
                     cmd_data.post_len = fill_base + 1'b1;
                     fill_in           = '0;
                  end else begin
                     fill_in = fill_base + 1'b1;
                  end
               end
            end
            MODE_TICK: begin
               if (conn_ff && fill_ff != '0) begin
                  if (idle_ff != '1) begin
                     idle_in = idle_ff + 1'b1;
                  end
                  if (fire) begin
                     cmd_push            = 1'b1;
                     cmd_data.post_len   = fill_ff;
                     cmd_data.post_cause = CAUSE_IDLE;
                     fill_in             = '0;
                     idle_in             = '0;
                  end
               end
            end
            MODE_CONNECT: begin
               if (!conn_ff) begin
                  fill_in = '0;
                  conn_in = 1'b1;
               end
            end
            MODE_DISCONNECT: begin
               conn_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RST;
         term_ff    <= TERM_RST;
         tmo_ff     <= TMO_RST;
         fill_ff    <= '0;
         idle_ff    <= '0;
         conn_ff    <= 1'b0;
      end else begin
         max_len_ff <= max_len_in;
         term_ff    <= term_in;
         tmo_ff     <= tmo_in;
         fill_ff    <= fill_in;
         idle_ff    <= idle_in;
         conn_ff    <= conn_in;
      end
   end

   // fill count never passes the store depth
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_W'(FRAME_DEPTH))
      else $error("fill count beyond frame depth");

   // a byte taken while connected restarts the idle count
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == MODE_BYTE && conn_ff) |=> (idle_ff == '0))
      else $error("idle count not cleared by byte");

endmodule

// File: sv/stpf_back.sv
module stpf_back import stpf_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_empty,
   input  cmd_type                        cmd_rdata,
   output logic                           cmd_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   input  logic                           out_full,
   output logic                           out_push,
   output out_type                        out_data
);

   localparam int ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int OCNT_W = $clog2(OUT_DEPTH+1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PRE,
      S_WRITE,
      S_POST
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;
   cause_type         rd_cause_ff, rd_cause_in;
   logic              rd_issue;
   logic              mem_we;
   logic              credit_ok;
   logic [LEN_W-1:0]  idx_next;
   logic [BYTE_W-1:0] mem_ff [FRAME_DEPTH];
   logic [BYTE_W-1:0] mem_q_ff;

   // room in the result queue for one more read in flight
   assign credit_ok = ((OCNT_W+1)'(out_count) + (OCNT_W+1)'(rd_pend_ff))
                      < (OCNT_W+1)'(OUT_DEPTH);
   assign idx_next  = idx_ff + 1'b1;

   // sequencer: flush before, store, flush after
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      rd_issue    = 1'b0;
      rd_last_in  = rd_last_ff;
      rd_cause_in = rd_cause_ff;
      mem_we      = 1'b0;
      cmd_pop     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_rdata;
               idx_in   = '0;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            if (idx_ff == cmd_ff.pre_len) begin
               idx_in   = '0;
               state_in = S_WRITE;
            end else if (credit_ok) begin
               rd_issue    = 1'b1;
               rd_last_in  = (idx_next == cmd_ff.pre_len);
               rd_cause_in = CAUSE_LEN;
               idx_in      = idx_next;
            end
         end
         S_WRITE: begin
            mem_we   = cmd_ff.wr_en;
            state_in = S_POST;
         end
         S_POST: begin
            if (idx_ff == cmd_ff.post_len) begin
               state_in = S_IDLE;
            end else if (credit_ok) begin
               rd_issue    = 1'b1;
               rd_last_in  = (idx_next == cmd_ff.post_len);
               rd_cause_in = cmd_ff.post_cause;
               idx_in      = idx_next;
            end
         end
      endcase
      rd_pend_in = rd_issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         rd_pend_ff  <= 1'b0;
         rd_last_ff  <= 1'b0;
         rd_cause_ff <= CAUSE_TERM;
         cmd_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         rd_pend_ff  <= rd_pend_in;
         rd_last_ff  <= rd_last_in;
         rd_cause_ff <= rd_cause_in;
         cmd_ff      <= cmd_in;
      end
   end

   // frame store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[cmd_ff.wr_addr[ADDR_W-1:0]] <= cmd_ff.wr_data;
      end
      if (rd_issue) begin
         mem_q_ff <= mem_ff[idx_ff[ADDR_W-1:0]];
      end
   end

   assign out_push = rd_pend_ff;
   assign out_data = '{frame_byte: mem_q_ff, frame_last: rd_last_ff,
                       flush_cause: rd_cause_ff};

   // a read in flight always finds room in the result queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !out_full)
      else $error("result queue overflow");

   // read index stays within the pre-flush length
   a_pre_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PRE) |-> (idx_ff <= cmd_ff.pre_len))
      else $error("pre-flush index past length");

   // work is taken only while idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == S_IDLE && !cmd_empty))
      else $error("command taken while busy");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench import stpf_pkg::*; ();

   localparam int FRAME_DEPTH  = FRAME_DEPTH_DEF;
   localparam int HADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 15;
   localparam int OPENING_ROWS = 30;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [1:0]        reg_idx;
      mode_type          mode;
      logic [BYTE_W-1:0] data;
      bit                typed;
      int                n_typed;
      out_type           typed_out;
   } plan_row_type;

   // clock, reset and block inputs
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic [1:0]        req_mode = MODE_BYTE;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic              rsp_pop = 1'b0;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = REG_MAX_LEN;
   logic [BYTE_W-1:0] csr_wdata = '0;
   logic              req_full;
   logic              rsp_empty;
   logic [BYTE_W-1:0] rsp_frame_byte;
   logic              rsp_frame_last;
   logic [1:0]        rsp_flush_cause;

   // framer state as the testbench sees it
   logic [BYTE_W-1:0] held_bytes [FRAME_DEPTH];
   logic [LEN_W-1:0]  held = '0;
   logic [IDLE_W-1:0] idle_cnt = '0;
   bit                link_up = 1'b0;
   logic [LEN_W-1:0]  cfg_max_len = MAX_LEN_RST;
   logic [BYTE_W-1:0] cfg_term = TERM_RST;
   logic [TMO_W-1:0]  cfg_timeout = TMO_RST;

   out_type frames_due [$];
   int      mismatches = 0;
   int      cycles = 0;
   int      words_done = 0;
   bit      stalls_on = 1'b1;
   int      stall_left = 0;

   // opening table: typed expectations only where obvious
   plan_row_type opening [OPENING_ROWS] = '{
      // after reset, not connected
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h41, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_TICK,       8'h00, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_DISCONNECT, 8'h00, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_CONNECT,    8'h00, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_CONNECT,    8'h00, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h0d, 1'b1, 1, '{8'h0d, 1'b1, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h00, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'hff, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      // zero timeout: first tick with pending bytes flushes
      '{ROW_CSR,  REG_TIMEOUT, MODE_BYTE,       8'h00, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_TICK,       8'h00, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_TICK,       8'h00, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h5a, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_TICK,       8'h00, 1'b1, 1, '{8'h5a, 1'b1, CAUSE_IDLE}},
      // one-byte frames, length flush then terminator
      '{ROW_CSR,  REG_MAX_LEN, MODE_BYTE,       8'h01, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h01, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h02, 1'b1, 1, '{8'h01, 1'b1, CAUSE_LEN}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h0d, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      // zero length acts as one
      '{ROW_CSR,  REG_MAX_LEN, MODE_BYTE,       8'h00, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h80, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h7f, 1'b1, 1, '{8'h80, 1'b1, CAUSE_LEN}},
      // top extremes of the registers
      '{ROW_CSR,  REG_MAX_LEN, MODE_BYTE,       8'h3f, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_CSR,  REG_TERM,    MODE_BYTE,       8'h00, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_CSR,  REG_TIMEOUT, MODE_BYTE,       8'hff, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h00, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_CSR,  REG_TERM,    MODE_BYTE,       8'hff, 1'b0, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'hff, 1'b1, 1, '{8'hff, 1'b1, CAUSE_TERM}},
      // disconnected bytes are dropped, connect leaves nothing pending
      '{ROW_WORD, REG_MAX_LEN, MODE_DISCONNECT, 8'h00, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_BYTE,       8'h33, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_CONNECT,    8'h00, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}},
      '{ROW_WORD, REG_MAX_LEN, MODE_TICK,       8'h00, 1'b1, 0, '{8'h00, 1'b0, CAUSE_TERM}}
   };

   serial_to_packet_framer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_rx_byte     (req_rx_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_flush_cause (rsp_flush_cause),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // effective frame length limit
   function automatic logic [LEN_W-1:0] frame_cap();
      if (cfg_max_len == 0)
         return LEN_W'(1);
      if (cfg_max_len > FRAME_DEPTH)
         return LEN_W'(FRAME_DEPTH);
      return cfg_max_len;
   endfunction

   // queue every held byte as one frame
   function automatic void flush_frame(cause_type cause);
      int i;
      for (i = 0; i < held; i++) begin
         frames_due.push_back('{held_bytes[HADDR_W'(i)], (i + 1 == held), cause});
      end
      held = '0;
   endfunction

   // advance the framer state by one word; returns 0 if the word is ignored
   function automatic bit frame_predict(mode_type m, logic [BYTE_W-1:0] b);
      bit fire;
      case (m)
         MODE_BYTE: begin
            if (!link_up)
               return 1'b0;
            idle_cnt = '0;
            if (held >= frame_cap())
               flush_frame(CAUSE_LEN);
            if (held < FRAME_DEPTH) begin
               held_bytes[held[HADDR_W-1:0]] = b;
               held = held + 1'b1;
            end
            if (b == cfg_term)
               flush_frame(CAUSE_TERM);
            return 1'b1;
         end
         MODE_TICK: begin
            if (!link_up || held == 0)
               return 1'b0;
            fire = (idle_cnt / 4) >= cfg_timeout;
            if (idle_cnt != '1)
               idle_cnt = idle_cnt + 1'b1;
            if (fire) begin
               flush_frame(CAUSE_IDLE);
               idle_cnt = '0;
            end
            return 1'b1;
         end
         MODE_CONNECT: begin
            if (link_up)
               return 1'b0;
            held = '0;
            link_up = 1'b1;
            return 1'b1;
         end
         default: begin
            if (!link_up)
               return 1'b0;
            link_up = 1'b0;
            return 1'b1;
         end
      endcase
   endfunction

   // push one word, called and returning at a falling edge
   task automatic send_word(input mode_type m, input logic [BYTE_W-1:0] b, input bit typed,
                            input int n_typed, input out_type typed_out, output bit took);
      int gap;
      int n0;
      gap = (stalls_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_mode <= m;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      n0 = frames_due.size();
      took = frame_predict(m, b);
      if (typed) begin
         while (frames_due.size() > n0)
            frames_due.delete(frames_due.size() - 1);
         if (n_typed == 1)
            frames_due.push_back(typed_out);
      end
      @(negedge clock);
   endtask

   // random-part word, counted only if the block acts on it
   task automatic send_plain(input mode_type m, input logic [BYTE_W-1:0] b);
      bit took;
      send_word(m, b, 1'b0, 0, '0, took);
      if (took)
         words_done++;
   endtask

   // stop sending and let the block go quiet
   task automatic settle();
      req_push <= 1'b0;
      while (frames_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         REG_MAX_LEN: cfg_max_len = val[LEN_W-1:0];
         REG_TERM:    cfg_term = val;
         REG_TIMEOUT: cfg_timeout = val;
         default: ;
      endcase
   endtask

   // receiver with random stall bursts
   always @(negedge clock) begin
      if (stall_left == 0 && stalls_on && $urandom_range(0, 9) == 0)
         stall_left = $urandom_range(1, 14);
      if (stall_left != 0) begin
         rsp_pop <= 1'b0;
         stall_left--;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // compare each popped word with the oldest expected one
   always @(posedge clock) begin : rsp_check
      out_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (frames_due.size() == 0) begin
            $error("unexpected frame word: byte %0h last %0b cause %0d",
                   rsp_frame_byte, rsp_frame_last, rsp_flush_cause);
            mismatches++;
         end else begin
            want = frames_due.pop_front();
            if (rsp_frame_byte !== want.frame_byte) begin
               $error("frame_byte: expected %0h, got %0h", want.frame_byte, rsp_frame_byte);
               mismatches++;
            end
            if (rsp_frame_last !== want.frame_last) begin
               $error("frame_last: expected %0b, got %0b", want.frame_last, rsp_frame_last);
               mismatches++;
            end
            if (rsp_flush_cause !== want.flush_cause) begin
               $error("flush_cause: expected %0d, got %0d", want.flush_cause,
                      rsp_flush_cause);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int r;
      int phase;
      int phase_start;
      int n;
      int k;
      bit took;
      logic [LEN_W-1:0] len_pick;
      logic [TMO_W-1:0] tmo_pick;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (r = 0; r < OPENING_ROWS; r++) begin
         if (opening[r].kind == ROW_CSR) begin
            settle();
            write_reg(opening[r].reg_idx, opening[r].data);
         end else begin
            send_word(opening[r].mode, opening[r].data, opening[r].typed,
                      opening[r].n_typed, opening[r].typed_out, took);
         end
      end

      // random phases, each with its own register setting
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         stalls_on = (phase != PHASES - 1);
         if (phase == 1)
            len_pick = LEN_W'(32);
         else if ($urandom_range(0, 3) == 0)
            len_pick = LEN_W'($urandom_range(0, 63));
         else
            len_pick = LEN_W'($urandom_range(1, 6));
         if (phase == 2)
            tmo_pick = '1;
         else if ($urandom_range(0, 3) == 0)
            tmo_pick = TMO_W'($urandom_range(0, 255));
         else
            tmo_pick = TMO_W'($urandom_range(0, 2));
         write_reg(REG_MAX_LEN, BYTE_W'(len_pick));
         write_reg(REG_TERM, BYTE_W'($urandom_range(0, 255)));
         write_reg(REG_TIMEOUT, tmo_pick);

         phase_start = words_done;
         while (words_done - phase_start < PHASE_WORDS) begin
            case ($urandom_range(0, 9))
               // noise
               0: begin
                  repeat ($urandom_range(1, 3))
                     send_plain(mode_type'($urandom_range(0, 3)),
                                BYTE_W'($urandom_range(0, 255)));
               end
               // drop the link, stray words, reconnect
               1: begin
                  send_plain(MODE_DISCONNECT, BYTE_W'($urandom_range(0, 255)));
                  repeat ($urandom_range(0, 2))
                     send_plain(mode_type'($urandom_range(0, 1)),
                                BYTE_W'($urandom_range(0, 255)));
                  send_plain(MODE_CONNECT, BYTE_W'($urandom_range(0, 255)));
               end
               // a frame body and one of the ways to end it
               default: begin
                  if (!link_up && $urandom_range(0, 4) != 0)
                     send_plain(MODE_CONNECT, '0);
                  n = $urandom_range(1, int'(frame_cap()) + 1);
                  repeat (n)
                     send_plain(MODE_BYTE, BYTE_W'($urandom_range(0, 255)));
                  case ($urandom_range(0, 2))
                     0: send_plain(MODE_BYTE, cfg_term);
                     1: begin
                        if (cfg_timeout <= 3)
                           k = 4 * cfg_timeout + 1 + $urandom_range(0, 1);
                        else
                           k = $urandom_range(1, 5);
                        repeat (k)
                           send_plain(MODE_TICK, BYTE_W'($urandom_range(0, 255)));
                     end
                     default: ;
                  endcase
               end
            endcase
         end
      end

      settle();
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: serial_to_packet_framer_top.f
sv/stpf_pkg.sv
sv/stpf_fifo.sv
sv/stpf_front.sv
sv/stpf_back.sv
sv/serial_to_packet_framer_top.sv
test/testbench.sv
